>>> sv/rdsm_pkg.sv
// ----------------------------------------------------------------------------
// rdsm_pkg - shared types and constants for the dot-star pattern matcher
// Pattern capacity, character codes, register indexes and the decoded
// pattern bundle passed from the register file to the row update logic.
// ----------------------------------------------------------------------------
package rdsm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int ROW_W       = PATTERN_MAX + 1;
  localparam int LEN_W       = 6;
  localparam int WORD_W      = 64;
  localparam int NUM_WORDS   = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = WORD_W;
  localparam int CHAR_W      = 8;
  // levels of the stride-two prefix scan: each chain holds ceil(ROW_W/2) bits
  localparam int SCAN_LEVELS = $clog2((ROW_W + 1) / 2);

  localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
  localparam logic [CHAR_W-1:0] DOT_CHAR  = 8'h2E;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_WORD_0 = 3'd1,
    REG_PATTERN_WORD_1 = 3'd2,
    REG_PATTERN_WORD_2 = 3'd3,
    REG_PATTERN_WORD_3 = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_BEGIN  = 1'b0,
    OP_APPEND = 1'b1
  } op_t;

  typedef struct packed {
    logic [LEN_W-1:0]                   len;        // clamped to PATTERN_MAX
    logic                               lead_star;
    logic [PATTERN_MAX-1:0]             is_star;
    logic [PATTERN_MAX-1:0]             is_dot;
    logic [PATTERN_MAX-1:0][CHAR_W-1:0] chars;
  } pat_info_t;

endpackage

>>> sv/rdsm_cfg_regs.sv
// ----------------------------------------------------------------------------
// rdsm_cfg_regs - pattern register file
// Holds the length and the four pattern words, and decodes them into per
// position star and dot flags for the row update.
// ----------------------------------------------------------------------------
module rdsm_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [rdsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rdsm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rdsm_pkg::pat_info_t               pat
);

  logic [rdsm_pkg::LEN_W-1:0]                              len_r;
  logic [rdsm_pkg::LEN_W-1:0]                              len_nxt;
  logic [rdsm_pkg::NUM_WORDS-1:0][rdsm_pkg::WORD_W-1:0]    word_r;
  logic [rdsm_pkg::NUM_WORDS-1:0][rdsm_pkg::WORD_W-1:0]    word_nxt;

  always_comb begin
    len_nxt  = len_r;
    word_nxt = word_r;
    if (cfg_wr_en) begin
      unique case (rdsm_pkg::cfg_reg_t'(cfg_index))
        rdsm_pkg::REG_PATTERN_LENGTH: len_nxt   = cfg_data[rdsm_pkg::LEN_W-1:0];
        rdsm_pkg::REG_PATTERN_WORD_0: word_nxt[0] = cfg_data;
        rdsm_pkg::REG_PATTERN_WORD_1: word_nxt[1] = cfg_data;
        rdsm_pkg::REG_PATTERN_WORD_2: word_nxt[2] = cfg_data;
        rdsm_pkg::REG_PATTERN_WORD_3: word_nxt[3] = cfg_data;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      word_r <= '0;
    end else begin
      len_r  <= len_nxt;
      word_r <= word_nxt;
    end
  end

  always_comb begin
    pat.chars = word_r;  // byte 0 of word 0 is pattern position 0
    if (len_r > rdsm_pkg::LEN_W'(rdsm_pkg::PATTERN_MAX)) begin
      pat.len = rdsm_pkg::LEN_W'(rdsm_pkg::PATTERN_MAX);
    end else begin
      pat.len = len_r;
    end
    for (int i = 0; i < rdsm_pkg::PATTERN_MAX; i++) begin
      pat.is_star[i] = (pat.chars[i] == rdsm_pkg::STAR_CHAR);
      pat.is_dot[i]  = (pat.chars[i] == rdsm_pkg::DOT_CHAR);
    end
    pat.lead_star = (pat.len != '0) && pat.is_star[0];
  end

endmodule

>>> sv/rdsm_row_step.sv
// ----------------------------------------------------------------------------
// rdsm_row_step - next prefix-match row
// Forms generate/propagate terms per position and resolves the star closure
// x[j] = g[j] | s[j] & x[j-2] with a log-depth prefix scan.
// ----------------------------------------------------------------------------
module rdsm_row_step (
  input  rdsm_pkg::pat_info_t                pat,
  input  rdsm_pkg::op_t                      op,
  input  logic [rdsm_pkg::CHAR_W-1:0]        text_char,
  input  logic [rdsm_pkg::ROW_W-1:0]         row_in,
  output logic [rdsm_pkg::ROW_W-1:0]         row_out,
  output logic                               matched,
  output logic                               hopeless
);

  logic [rdsm_pkg::PATTERN_MAX-1:0] fits;
  logic [rdsm_pkg::ROW_W-1:0]       gen;
  logic [rdsm_pkg::ROW_W-1:0]       prop;
  logic [rdsm_pkg::ROW_W-1:0]       g_lvl [rdsm_pkg::SCAN_LEVELS+1];
  logic [rdsm_pkg::ROW_W-1:0]       p_lvl [rdsm_pkg::SCAN_LEVELS+1];
  logic                             adv;

  assign adv = (op == rdsm_pkg::OP_APPEND);

  always_comb begin
    for (int i = 0; i < rdsm_pkg::PATTERN_MAX; i++) begin
      fits[i] = pat.is_dot[i] || (pat.chars[i] == text_char);
    end
  end

  always_comb begin
    gen  = '0;
    prop = '0;
    gen[0] = !adv;  // empty text matches the empty prefix
    for (int j = 1; j <= rdsm_pkg::PATTERN_MAX; j++) begin
      if (j <= int'(pat.len)) begin
        if (j > 1 && pat.is_star[j-1]) begin
          prop[j] = 1'b1;
          gen[j]  = adv && row_in[j] && fits[j-2];
        end else begin
          gen[j]  = adv && row_in[j-1] && fits[j-1];
        end
      end
    end
    if (pat.lead_star) begin
      gen  = '0;
      prop = '0;
    end
  end

  // stride-two scan, distances 2, 4, 8 ...
  always_comb begin
    g_lvl[0] = gen;
    p_lvl[0] = prop;
    for (int l = 0; l < rdsm_pkg::SCAN_LEVELS; l++) begin
      g_lvl[l+1] = g_lvl[l] | (p_lvl[l] & (g_lvl[l] << (2 << l)));
      p_lvl[l+1] = p_lvl[l] & (p_lvl[l] << (2 << l));
    end
  end

  // bits above the length are always clear, so the whole row can be reduced
  assign row_out  = g_lvl[rdsm_pkg::SCAN_LEVELS];
  assign matched  = row_out[pat.len];
  assign hopeless = ~|row_out;

endmodule

>>> sv/regex_dot_star_match_core.sv
// ----------------------------------------------------------------------------
// regex_dot_star_match_core - streaming '.' / '*' pattern matcher
// Matches a byte stream against a configured pattern of up to 32 characters.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle when the result side keeps up; each item
// passes through the input register, then the result register, before its
// result is presented. The rate is set by the prefix-row register, whose next
// value is computed combinationally from its current one for each item. A
// begin item loads the empty-text row; an append item advances the row by one
// byte.
// Write the pattern registers only while no item is in flight.
module regex_dot_star_match_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] text_char
  input  logic [0:0]                        in_tuser,   // [0] operation
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // [0] matched, [1] hopeless
  input  logic                              cfg_wr_en,
  input  logic [rdsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rdsm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rdsm_pkg::pat_info_t               pat;

  logic                              s1_valid_r;
  logic                              s1_valid_nxt;
  rdsm_pkg::op_t                     s1_op_r;
  logic [rdsm_pkg::CHAR_W-1:0]       s1_char_r;
  logic [rdsm_pkg::ROW_W-1:0]        row_r;
  logic [rdsm_pkg::ROW_W-1:0]        row_nxt;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic                              out_matched_r;
  logic                              out_hopeless_r;
  logic                              step_matched;
  logic                              step_hopeless;
  logic                              out_free;
  logic                              s1_fire;
  logic                              in_fire;

  rdsm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pat       (pat)
  );

  rdsm_row_step u_step (
    .pat       (pat),
    .op        (s1_op_r),
    .text_char (s1_char_r),
    .row_in    (row_r),
    .row_out   (row_nxt),
    .matched   (step_matched),
    .hopeless  (step_hopeless)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      row_r       <= rdsm_pkg::ROW_W'(1);
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= rdsm_pkg::op_t'(in_tuser[0]);
      s1_char_r <= in_tdata;
    end
    if (s1_fire) begin
      out_matched_r  <= step_matched;
      out_hopeless_r <= step_hopeless;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_hopeless_r, out_matched_r};

  // a full match always leaves a live prefix
  a_match_not_hopeless: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("matched and hopeless both set");

  // begin loads the empty prefix unless the pattern opens with a star
  a_begin_row: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_op_r == rdsm_pkg::OP_BEGIN) |=> (row_r[0] == !pat.lead_star))
    else $error("empty-text row has wrong bit zero");

  // any appended byte kills the empty prefix
  a_append_row: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_op_r == rdsm_pkg::OP_APPEND) |=> !row_r[0])
    else $error("bit zero survived a text byte");

  // a stalled item stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> s1_valid_r)
    else $error("input register item lost");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for regex_dot_star_match_core
// Streams begin/append items through the matcher under random idling on both
// sides and checks every verdict against a local prefix-row predictor.
// Covers directed corner cases, an output stall and random patterns and texts.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int PHASES       = 12;
  localparam int HOLD_CYCLES  = 300;

  typedef logic [rdsm_pkg::CHAR_W-1:0] byte_q_t[$];

  typedef struct packed {
    logic matched;
    logic hopeless;
  } verdict_t;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata = '0;   // [7:0] text_char
  logic [0:0]                      in_tuser = '0;   // [0] operation
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [7:0]                      out_tdata;       // [0] matched, [1] hopeless
  logic                            cfg_wr_en = 1'b0;
  logic [rdsm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rdsm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the pattern registers and the prefix row
  logic [rdsm_pkg::LEN_W-1:0]  pat_len_raw = '0;
  logic [rdsm_pkg::WORD_W-1:0] pat_words [rdsm_pkg::NUM_WORDS] = '{default: '0};
  logic [rdsm_pkg::ROW_W-1:0]  prefix_bits = rdsm_pkg::ROW_W'(1);
  verdict_t                    pending_verdicts[$];

  int     errors = 0;
  int     items_offered = 0;
  int     results_seen = 0;
  int     match_count = 0;
  int     hopeless_count = 0;
  int     settings_used = 0;
  int     in_idle_pct = 9;
  int     out_idle_pct = 9;
  int     hold_reqs = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  longint cycles = 0;

  regex_dot_star_match_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycles,
               pending_verdicts.size());
      $display("[regex_dot_star_match_core] ERROR");
      $finish;
    end
  end

  function automatic logic [rdsm_pkg::CHAR_W-1:0] pattern_byte(int pos);
    return pat_words[pos >> 3][(pos & 7) * 8 +: 8];
  endfunction

  function automatic logic byte_fits(logic [rdsm_pkg::CHAR_W-1:0] c,
                                     logic [rdsm_pkg::CHAR_W-1:0] p);
    return (p == rdsm_pkg::DOT_CHAR) || (c == p);
  endfunction

  function automatic int used_length();
    return (pat_len_raw > rdsm_pkg::PATTERN_MAX) ? rdsm_pkg::PATTERN_MAX
                                                 : int'(pat_len_raw);
  endfunction

  // Advances the predicted prefix row by one item and returns its verdict.
  function automatic verdict_t match_step(rdsm_pkg::op_t op,
                                          logic [rdsm_pkg::CHAR_W-1:0] c);
    int                        len;
    logic                      lead;
    logic                      any;
    logic [rdsm_pkg::ROW_W-1:0] nxt;
    verdict_t                  v;
    len  = used_length();
    lead = (len > 0) && (pattern_byte(0) == rdsm_pkg::STAR_CHAR);
    nxt  = '0;
    if (!lead) begin
      if (op == rdsm_pkg::OP_BEGIN) begin
        nxt[0] = 1'b1;
        for (int j = 2; j <= len; j++)
          nxt[j] = nxt[j-2] && (pattern_byte(j-1) == rdsm_pkg::STAR_CHAR);
      end else begin
        for (int j = 1; j <= len; j++) begin
          if (j > 1 && pattern_byte(j-1) == rdsm_pkg::STAR_CHAR)
            nxt[j] = nxt[j-2] || (prefix_bits[j] && byte_fits(c, pattern_byte(j-2)));
          else
            nxt[j] = prefix_bits[j-1] && byte_fits(c, pattern_byte(j-1));
        end
      end
    end
    prefix_bits = nxt;
    any = 1'b0;
    for (int j = 0; j <= len; j++)
      any = any | nxt[j];
    v.matched  = nxt[len] && !lead;
    v.hopeless = !any || lead;
    return v;
  endfunction

  // Result checking first, then prediction for the input transfer of this edge.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_verdicts.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %02h", $time,
                   out_tdata);
        end else begin
          want = pending_verdicts.pop_front();
          if (out_tdata[0] !== want.matched) begin
            errors++;
            $display("%0t: matched mismatch, expected %0b, actual %0b", $time,
                     want.matched, out_tdata[0]);
          end
          if (out_tdata[1] !== want.hopeless) begin
            errors++;
            $display("%0t: hopeless mismatch, expected %0b, actual %0b", $time,
                     want.hopeless, out_tdata[1]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = match_step(rdsm_pkg::op_t'(in_tuser[0]), in_tdata);
        pending_verdicts.insert(pending_verdicts.size(), want);
        if (want.matched)
          match_count++;
        if (want.hopeless)
          hopeless_count++;
      end
    end
  end

  // Result side: random idling, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  task automatic send_item(rdsm_pkg::op_t op, logic [rdsm_pkg::CHAR_W-1:0] ch);
    @(negedge clk);
    while (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = ch;
    do @(posedge clk); while (!in_tready);
    items_offered++;
  endtask

  task automatic send_text(byte_q_t txt, bit with_begin);
    if (with_begin)
      send_item(rdsm_pkg::OP_BEGIN, 8'($urandom));
    foreach (txt[i])
      send_item(rdsm_pkg::OP_APPEND, txt[i]);
  endtask

  // Block idle: all transfers done, every verdict back, pipeline flushed.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_verdicts.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(rdsm_pkg::cfg_reg_t idx,
                           logic [rdsm_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    if (idx == rdsm_pkg::REG_PATTERN_LENGTH)
      pat_len_raw = value[rdsm_pkg::LEN_W-1:0];
    else
      pat_words[int'(idx) - 1] = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic load_pattern(byte_q_t pat, logic [rdsm_pkg::CFG_DATA_W-1:0] len_val);
    logic [rdsm_pkg::WORD_W-1:0] words [rdsm_pkg::NUM_WORDS];
    foreach (words[k])
      words[k] = '0;
    foreach (pat[i])
      if (i < rdsm_pkg::PATTERN_MAX)
        words[i / 8][(i % 8) * 8 +: 8] = pat[i];
    write_reg(rdsm_pkg::REG_PATTERN_LENGTH, len_val);
    for (int k = 0; k < rdsm_pkg::NUM_WORDS; k++)
      write_reg(rdsm_pkg::cfg_reg_t'(k + 1), words[k]);
    settings_used++;
  endtask

  function automatic byte_q_t chars_of(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++)
      q.insert(q.size(), s[i]);
    return q;
  endfunction

  function automatic logic [rdsm_pkg::CHAR_W-1:0] random_letter();
    return 8'h61 + 8'($urandom_range(0, 2));
  endfunction

  function automatic byte_q_t random_pattern(int tokens);
    byte_q_t                     p;
    logic [rdsm_pkg::CHAR_W-1:0] ch;
    for (int k = 0; k < tokens && p.size() < rdsm_pkg::PATTERN_MAX; k++) begin
      case ($urandom_range(0, 3))
        0:       ch = "a";
        1:       ch = "b";
        2:       ch = "c";
        default: ch = rdsm_pkg::DOT_CHAR;
      endcase
      p.insert(p.size(), ch);
      if ($urandom_range(0, 99) < 40 && p.size() < rdsm_pkg::PATTERN_MAX)
        p.insert(p.size(), rdsm_pkg::STAR_CHAR);
      // the odd doubled star: a star applied to a literal star
      if ($urandom_range(0, 99) < 5 && p.size() < rdsm_pkg::PATTERN_MAX)
        p.insert(p.size(), rdsm_pkg::STAR_CHAR);
    end
    return p;
  endfunction

  // A text that the first len characters of the pattern would accept, unless it opens with a star.
  function automatic byte_q_t derive_text(byte_q_t pat, int len);
    byte_q_t                     t;
    int                          i;
    int                          reps;
    logic                        star;
    logic [rdsm_pkg::CHAR_W-1:0] c;
    i = 0;
    while (i < len) begin
      c    = pat[i];
      star = (i + 1 < len) && (pat[i+1] == rdsm_pkg::STAR_CHAR);
      reps = star ? $urandom_range(0, 3) : 1;
      repeat (reps) t.insert(t.size(), (c == rdsm_pkg::DOT_CHAR) ? random_letter() : c);
      i += star ? 2 : 1;
    end
    return t;
  endfunction

  // Reset row is the empty-text row of the empty pattern.
  task automatic test_reset_row();
    send_item(rdsm_pkg::OP_APPEND, 8'h00);
    send_item(rdsm_pkg::OP_BEGIN, 8'hFF);
    send_item(rdsm_pkg::OP_APPEND, 8'hFF);
    wait_drained();
  endtask

  task automatic test_literal_and_star();
    load_pattern(chars_of("a*b."), 4);
    send_text(chars_of("b."), 1'b1);
    send_text(chars_of("aabzz"), 1'b1);
    wait_drained();
  endtask

  task automatic test_leading_star();
    load_pattern(chars_of("*a"), 2);
    send_text(chars_of("a"), 1'b1);
    wait_drained();
  endtask

  task automatic test_dot_star();
    load_pattern(chars_of(".*"), 2);
    send_item(rdsm_pkg::OP_BEGIN, 8'h00);
    send_item(rdsm_pkg::OP_APPEND, 8'hFF);
    wait_drained();
  endtask

  // Largest length code (clamped) with all-ones words, then a full 32-char pattern.
  task automatic test_full_width();
    byte_q_t stars;
    write_reg(rdsm_pkg::REG_PATTERN_LENGTH, {rdsm_pkg::CFG_DATA_W{1'b1}});
    for (int k = 0; k < rdsm_pkg::NUM_WORDS; k++)
      write_reg(rdsm_pkg::cfg_reg_t'(k + 1), {rdsm_pkg::WORD_W{1'b1}});
    settings_used++;
    send_item(rdsm_pkg::OP_BEGIN, 8'h00);
    send_item(rdsm_pkg::OP_APPEND, 8'hFF);
    send_item(rdsm_pkg::OP_APPEND, 8'h00);
    wait_drained();
    for (int k = 0; k < rdsm_pkg::PATTERN_MAX / 2; k++) begin
      stars.insert(stars.size(), "a");
      stars.insert(stars.size(), rdsm_pkg::STAR_CHAR);
    end
    load_pattern(stars, rdsm_pkg::PATTERN_MAX);
    send_text(chars_of("a"), 1'b1);
    wait_drained();
  endtask

  // The row survives a pattern change and is carried into the new pattern.
  task automatic test_pattern_swap();
    load_pattern(chars_of("ab"), 2);
    send_text(chars_of("a"), 1'b1);
    wait_drained();
    load_pattern(chars_of("abc"), 3);
    send_text(chars_of("bc"), 1'b0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    load_pattern(chars_of(".*a"), 3);
    @(posedge clk);
    hold_reqs++;
    send_item(rdsm_pkg::OP_BEGIN, 8'h00);
    repeat (59) send_item(rdsm_pkg::OP_APPEND, $urandom_range(0, 1) ? 8'h61 : 8'h62);
    wait_drained();
  endtask

  task automatic test_random_text();
    byte_q_t                         pat;
    byte_q_t                         txt;
    logic [rdsm_pkg::CFG_DATA_W-1:0] len_val;
    int                              eff;
    int                              goal;
    int                              start;
    int                              r;
    logic [rdsm_pkg::CHAR_W-1:0]     ch;
    goal = RANDOM_ITEMS / PHASES;
    for (int phase = 0; phase < PHASES; phase++) begin
      // a long stretch with neither side idling
      in_idle_pct  = (phase == 3 || phase == 4) ? 0 : 9;
      out_idle_pct = in_idle_pct;
      if (phase == 5) begin
        for (int k = 0; k < rdsm_pkg::NUM_WORDS; k++)
          write_reg(rdsm_pkg::cfg_reg_t'(k + 1), {$urandom, $urandom});
        write_reg(rdsm_pkg::REG_PATTERN_LENGTH, {$urandom, $urandom});
        settings_used++;
        pat.delete();
        for (int i = 0; i < used_length(); i++)
          pat.insert(pat.size(), pattern_byte(i));
      end else begin
        case (phase)
          7: begin
            pat = random_pattern(3);
            pat.push_front(rdsm_pkg::STAR_CHAR);
            len_val = pat.size();
          end
          9: begin
            pat = random_pattern(4);
            len_val = 0;
          end
          10: begin
            pat = random_pattern($urandom_range(10, 20));
            len_val = pat.size();
          end
          11: begin
            pat = random_pattern(rdsm_pkg::PATTERN_MAX);
            len_val = $urandom_range(rdsm_pkg::PATTERN_MAX + 1, 63);
          end
          default: begin
            pat = random_pattern($urandom_range(1, 6));
            len_val = pat.size();
          end
        endcase
        load_pattern(pat, len_val);
      end
      eff = (used_length() < pat.size()) ? used_length() : pat.size();
      start = items_offered;
      while (items_offered - start < goal) begin
        r = $urandom_range(0, 99);
        txt.delete();
        if (r < 65) begin
          txt = derive_text(pat, eff);
          if (txt.size() != 0 && $urandom_range(0, 3) == 0)
            txt[$urandom_range(0, txt.size() - 1)] = random_letter();
          send_text(txt, 1'b1);
        end else if (r < 80) begin
          repeat ($urandom_range(0, 10)) begin
            case ($urandom_range(0, 3))
              0:       ch = "a";
              1:       ch = "b";
              2:       ch = rdsm_pkg::DOT_CHAR;
              default: ch = rdsm_pkg::STAR_CHAR;
            endcase
            txt.insert(txt.size(), ch);
          end
          send_text(txt, 1'b1);
        end else if (r < 92) begin
          repeat ($urandom_range(0, 8)) txt.insert(txt.size(), 8'($urandom));
          send_text(txt, 1'b1);
        end else begin
          // carry on the current text without a fresh begin
          repeat ($urandom_range(1, 4)) txt.insert(txt.size(), random_letter());
          send_text(txt, 1'b0);
        end
      end
      wait_drained();
    end
    in_idle_pct  = 9;
    out_idle_pct = 9;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_row();
    test_literal_and_star();
    test_leading_star();
    test_dot_star();
    test_full_width();
    test_pattern_swap();
    test_backpressure();
    test_random_text();

    repeat (10) @(posedge clk);
    $display("Streamed %0d items under %0d pattern settings, with a %0d-cycle output stall.",
             items_offered, settings_used, HOLD_CYCLES);
    $display("Checked %0d verdicts: %0d whole-pattern matches, %0d hopeless rows.",
             results_seen, match_count, hopeless_count);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("[regex_dot_star_match_core] OK");
    end else begin
      $display("%0d mismatches, %0d verdicts never returned", errors,
               pending_verdicts.size());
      $display("[regex_dot_star_match_core] ERROR");
    end
    $finish;
  end

endmodule
